[rtl/core/tqv_pkg.sv]
// Shared widths, register indexes, types and helpers of the tile quad vertex generator.
package tqv_pkg;

    localparam int GRID_W     = 12;
    localparam int IDX_W      = 16;
    localparam int SIZE_W     = 9;
    localparam int ALPHA_W    = 8;
    localparam int CORNER_W   = 2;
    localparam int POS_W      = 21;
    localparam int TEXU_W     = 17;
    localparam int TEXV_W     = 25;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam int MAP_TILES_DEF = 4096;
    // one restoring division step per cell, one cell per quotient bit
    localparam int DIV_STEPS = IDX_W;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_ALPHA   = 8'd3;

    localparam logic [SIZE_W-1:0]   SIZE_RESET  = 9'd16;
    localparam logic [SIZE_W-1:0]   SIZE_MAX    = 9'd256;
    localparam logic [SIZE_W-1:0]   SIZE_MIN    = 9'd1;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 8'hff;
    localparam logic [CORNER_W-1:0] CORNER_TL   = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

    typedef struct packed {
        logic [GRID_W-1:0] col;
        logic [GRID_W-1:0] row;
        logic              fd;
        logic              fh;
        logic              fv;
    } t_tile;

    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [IDX_W-1:0]  dq;
    } t_div;

    typedef struct packed {
        logic [SIZE_W-1:0] tw;
        logic [SIZE_W-1:0] th;
        logic [SIZE_W-1:0] tpr;
    } t_geom;

    typedef struct packed {
        logic [POS_W-1:0]  x0;
        logic [POS_W-1:0]  y0;
        logic [TEXU_W-1:0] u0;
        logic [TEXV_W-1:0] v0;
        logic              fd;
        logic              fh;
        logic              fv;
    } t_quad;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_MIN;
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/core/tqv_ifs.sv]
// Handshake channel interfaces: tile input, vertex output and register writes.
interface tqv_tile_if import tqv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GRID_W-1:0] grid_col;
    logic [GRID_W-1:0] grid_row;
    logic [IDX_W-1:0]  tile_index;
    logic              flip_diag;
    logic              flip_horiz;
    logic              flip_vert;

    modport source (output valid, grid_col, grid_row, tile_index, flip_diag, flip_horiz,
                    flip_vert, input ready);
    modport sink (input valid, grid_col, grid_row, tile_index, flip_diag, flip_horiz,
                  flip_vert, output ready);
endinterface

interface tqv_vtx_if import tqv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CORNER_W-1:0] corner;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [TEXU_W-1:0]   tex_u;
    logic [TEXV_W-1:0]   tex_v;
    logic [ALPHA_W-1:0]  alpha;
    logic                last;

    modport source (output valid, corner, pos_x, pos_y, tex_u, tex_v, alpha, last,
                     input ready);
    modport sink (input valid, corner, pos_x, pos_y, tex_u, tex_v, alpha, last,
                  output ready);
endinterface

interface tqv_cfg_if import tqv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/tqv_div_cell.sv]
// One cell of the divider chain: a restoring division step, tile data carried alongside.
module tqv_div_cell import tqv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [SIZE_W-1:0] i_tpr,
    input  logic              i_valid,
    input  t_tile             i_tile,
    input  t_div              i_div,
    output logic              o_valid,
    output t_tile             o_tile,
    output t_div              o_div
);

    logic              r_valid;
    t_tile             r_tile;
    t_div              r_div;
    t_div              n_div;
    logic [SIZE_W:0]   w_trial;
    logic [SIZE_W:0]   w_diff;
    logic              w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {i_div.rem, i_div.dq[IDX_W-1]};
    assign w_diff  = w_trial - {1'b0, i_tpr};
    assign w_ge    = w_trial >= {1'b0, i_tpr};

    always_comb begin
        n_div.rem = w_ge ? w_diff[SIZE_W-1:0] : w_trial[SIZE_W-1:0];
        n_div.dq  = {i_div.dq[IDX_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tile <= i_tile;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_tile  = r_tile;
    assign o_div   = r_div;

endmodule

[rtl/core/tqv_scale.sv]
// Scaling stage: grid and texture cell coordinates times the tile size, registered.
module tqv_scale import tqv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_tile i_tile,
    input  t_div  i_div,
    input  t_geom i_geom,
    output logic  o_valid,
    input  logic  i_ready,
    output t_quad o_quad
);

    logic  r_valid;
    t_quad r_quad;
    t_quad n_quad;

    assign o_ready = !r_valid || i_ready;

    // remainder is the texture column, quotient the texture row
    always_comb begin
        n_quad.x0 = POS_W'(i_tile.col) * POS_W'(i_geom.tw);
        n_quad.y0 = POS_W'(i_tile.row) * POS_W'(i_geom.th);
        n_quad.u0 = TEXU_W'(i_div.rem) * TEXU_W'(i_geom.tw);
        n_quad.v0 = TEXV_W'(i_div.dq) * TEXV_W'(i_geom.th);
        n_quad.fd = i_tile.fd;
        n_quad.fh = i_tile.fh;
        n_quad.fv = i_tile.fv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quad <= n_quad;
        end
    end

    assign o_valid = r_valid;
    assign o_quad  = r_quad;

endmodule

[rtl/core/tqv_corner_seq.sv]
// Corner sequencer: holds one quad and emits its four corners, one per transaction.
module tqv_corner_seq import tqv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_quad              i_quad,
    input  t_geom              i_geom,
    input  logic [ALPHA_W-1:0] i_alpha,
    tqv_vtx_if.source          o_vtx
);

    logic                r_valid;
    logic [CORNER_W-1:0] r_cnt;
    t_quad               r_quad;
    logic                w_right;
    logic                w_bottom;
    logic                w_r1;
    logic                w_b1;
    logic                w_src_r;
    logic                w_src_b;
    logic                w_done;

    assign w_done  = o_vtx.ready && (r_cnt == CORNER_LAST);
    assign o_ready = !r_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= CORNER_TL;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
            r_cnt   <= CORNER_TL;
        end else if (r_valid && o_vtx.ready) begin
            if (r_cnt == CORNER_LAST) begin
                r_valid <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_quad <= i_quad;
        end
    end

    // corners 1 and 2 sit on the right edge, 2 and 3 on the bottom edge
    assign w_right  = r_cnt[0] ^ r_cnt[1];
    assign w_bottom = r_cnt[1];

    // source texture corner: vertical flip, then horizontal, then diagonal transpose
    assign w_r1    = w_right ^ r_quad.fh;
    assign w_b1    = w_bottom ^ r_quad.fv;
    assign w_src_r = r_quad.fd ? w_b1 : w_r1;
    assign w_src_b = r_quad.fd ? w_r1 : w_b1;

    assign o_vtx.valid  = r_valid;
    assign o_vtx.corner = r_cnt;
    assign o_vtx.pos_x  = r_quad.x0 + (w_right ? POS_W'(i_geom.tw) : '0);
    assign o_vtx.pos_y  = r_quad.y0 + (w_bottom ? POS_W'(i_geom.th) : '0);
    assign o_vtx.tex_u  = r_quad.u0 + (w_src_r ? TEXU_W'(i_geom.tw) : '0);
    assign o_vtx.tex_v  = r_quad.v0 + (w_src_b ? TEXV_W'(i_geom.th) : '0);
    assign o_vtx.alpha  = i_alpha;
    assign o_vtx.last   = (r_cnt == CORNER_LAST);

endmodule

[rtl/core/tile_quad_vertex_generator.sv]
// Pipeline: a tile passes through 16 divider cells, one scaling stage and one corner register
// before its first corner is on the output; the other three corners follow it in order.
// The output port moves one corner per cycle while o_vtx.ready is high, and a tile leaves
// only with its fourth corner; the divider chain takes a new tile in any cycle in which its
// last cell is empty or the scaling stage can take that cell's tile.
// Reset (synchronous, active low) empties the pipeline and loads tile size 16, 16 tiles
// per row and alpha 255.
module tile_quad_vertex_generator import tqv_pkg::*; #(
    parameter int MAP_TILES = MAP_TILES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tqv_tile_if.sink  i_tile,
    tqv_cfg_if.sink   i_cfg,
    tqv_vtx_if.source o_vtx
);

    localparam logic [31:0] GRID_MAX = 32'(MAP_TILES - 1);

    logic [SIZE_W-1:0]  r_tw;
    logic [SIZE_W-1:0]  r_th;
    logic [SIZE_W-1:0]  r_tpr;
    logic [ALPHA_W-1:0] r_alpha;
    t_geom              w_geom;

    logic  w_valid [DIV_STEPS+1];
    t_tile w_tile  [DIV_STEPS+1];
    t_div  w_div   [DIV_STEPS+1];
    logic  w_adv;
    logic  w_scale_ready;
    logic  w_scale_valid;
    t_quad w_quad;
    logic  w_seq_ready;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw    <= SIZE_RESET;
            r_th    <= SIZE_RESET;
            r_tpr   <= SIZE_RESET;
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TILE_WIDTH:    r_tw    <= clamp_size(i_cfg.data);
                REG_TILE_HEIGHT:   r_th    <= clamp_size(i_cfg.data);
                REG_TILES_PER_ROW: r_tpr   <= clamp_size(i_cfg.data);
                REG_LAYER_ALPHA:   r_alpha <= i_cfg.data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_geom = '{tw: r_tw, th: r_th, tpr: r_tpr};

    // advance the whole chain unless its last cell is held
    assign w_adv        = !w_valid[DIV_STEPS] || w_scale_ready;
    assign i_tile.ready = w_adv;

    always_comb begin
        w_valid[0]    = i_tile.valid;
        w_tile[0].col = (32'(i_tile.grid_col) > GRID_MAX) ? GRID_MAX[GRID_W-1:0]
                                                          : i_tile.grid_col;
        w_tile[0].row = (32'(i_tile.grid_row) > GRID_MAX) ? GRID_MAX[GRID_W-1:0]
                                                          : i_tile.grid_row;
        w_tile[0].fd  = i_tile.flip_diag;
        w_tile[0].fh  = i_tile.flip_horiz;
        w_tile[0].fv  = i_tile.flip_vert;
        w_div[0].rem  = '0;
        w_div[0].dq   = i_tile.tile_index;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        tqv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tpr   (r_tpr),
            .i_valid (w_valid[g]),
            .i_tile  (w_tile[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_tile  (w_tile[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    tqv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[DIV_STEPS]),
        .o_ready (w_scale_ready),
        .i_tile  (w_tile[DIV_STEPS]),
        .i_div   (w_div[DIV_STEPS]),
        .i_geom  (w_geom),
        .o_valid (w_scale_valid),
        .i_ready (w_seq_ready),
        .o_quad  (w_quad)
    );

    tqv_corner_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_scale_valid),
        .o_ready (w_seq_ready),
        .i_quad  (w_quad),
        .i_geom  (w_geom),
        .i_alpha (r_alpha),
        .o_vtx   (o_vtx)
    );

endmodule

[rtl/core/tqv_checker.sv]
// Port-level checks of the vertex stream, bound to the top level.
module tqv_checker import tqv_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [CORNER_W-1:0]   i_corner,
    input logic                  i_last,
    input logic [ALPHA_W-1:0]    i_alpha,
    input logic                  i_cfg_valid,
    input logic                  i_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CORNER_W-1:0] r_exp_corner;
    logic [ALPHA_W-1:0]  r_alpha;

    // track the corner expected next and the alpha last written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_corner <= CORNER_TL;
            r_alpha      <= ALPHA_RESET;
        end else begin
            if (i_out_valid && i_out_ready) begin
                r_exp_corner <= r_exp_corner + 1'b1;
            end
            if (i_cfg_valid && i_cfg_ready && (i_cfg_index == REG_LAYER_ALPHA)) begin
                r_alpha <= i_cfg_data[ALPHA_W-1:0];
            end
        end
    end

    a_last_on_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_corner == CORNER_LAST)))
        else $error("last flag does not match the fourth corner");

    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_corner == r_exp_corner))
        else $error("corner out of order");

    a_alpha_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_alpha == r_alpha))
        else $error("vertex alpha differs from layer alpha");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_corner)))
        else $error("stalled vertex dropped or changed");

endmodule

bind tile_quad_vertex_generator tqv_checker u_tqv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_vtx.valid),
    .i_out_ready (o_vtx.ready),
    .i_corner    (o_vtx.corner),
    .i_last      (o_vtx.last),
    .i_alpha     (o_vtx.alpha),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data)
);
